// ----- rtl/tvsg_pkg.sv -----
// ----------------------------------------------------------------------------
// tvsg_pkg - shared types and constants of the three voice sound generator
// Opcodes, register numbers, read masks, fixed volume map and the
// logarithmic volume table builder.
// ----------------------------------------------------------------------------
package tvsg_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LATCH = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    // Sound chip register numbers
    localparam logic [3:0] REG_NOISE_PER  = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
    localparam logic [3:0] REG_PORT_A     = 4'd14;
    localparam logic [3:0] REG_PORT_B     = 4'd15;

    // Configuration register indexes
    localparam logic [2:0] CFG_AY_MODE     = 3'd0;
    localparam logic [2:0] CFG_STEREO_MODE = 3'd1;
    localparam logic [2:0] CFG_WEIGHT_BASE = 3'd2;

    localparam int VOL_W    = 14;
    localparam int SAMPLE_W = 15;

    // Attenuation step 2^(-1/6.36) in Q30
    localparam logic [63:0] ATT_STEP = 64'd962871006;
    localparam logic [63:0] ATT_DIV  = 64'd3 << 30;

    typedef logic [31:0][VOL_W-1:0] vol_table_t;

    // Snapshot of chip state that feeds the mixer
    typedef struct packed {
        logic [2:0]      tone_sq;
        logic            noise_sq;
        logic [7:0]      mixer;
        logic [2:0][4:0] vol_ctrl;
        logic [3:0]      shape;
        logic [5:0]      env_step;
        logic [7:0]      port_a;
        logic [7:0]      port_b;
        logic [7:0]      read_data;
    } mix_src_t;

    function automatic logic [7:0] read_mask(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0f;
            4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1f;
            default:                 m = 8'hff;
        endcase
        return m;
    endfunction

    // 0, 3, 5, ... 31
    function automatic logic [4:0] fixed_level(input logic [3:0] n);
        return (n == 4'd0) ? 5'd0 : {n, 1'b1};
    endfunction

    function automatic vol_table_t build_vol_rom(input int unsigned full_scale);
        logic [63:0] att [32];
        logic [63:0] raw0;
        logic [63:0] rawv;
        vol_table_t  rom;
        att[0] = 64'd1 << 30;
        for (int k = 1; k < 32; k++)
        begin
            att[k] = (att[k-1] * ATT_STEP) >> 30;
        end
        raw0 = (64'(full_scale) * att[31]) / ATT_DIV;
        for (int v = 0; v < 32; v++)
        begin
            rawv   = (64'(full_scale) * att[v ^ 31]) / ATT_DIV;
            rom[v] = VOL_W'(rawv - raw0);
        end
        return rom;
    endfunction

endpackage

// ----- rtl/tvsg_mixer.sv -----
// ----------------------------------------------------------------------------
// tvsg_mixer - envelope shaping, gating, volume lookup and stereo or mono mix
// Three register stages: channel levels, weighted products, output register.
// ----------------------------------------------------------------------------
module tvsg_mixer #(
    parameter int FULL_SCALE = 32767
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    input  tvsg_pkg::mix_src_t              src,
    input  logic                            ay_mode,
    input  logic                            stereo_mode,
    input  logic [5:0][7:0]                 weight,
    input  logic                            out_stall,
    output logic                            adv,
    output logic                            out_valid,
    output logic [7:0]                      read_data,
    output logic [tvsg_pkg::SAMPLE_W-1:0]   left_sample,
    output logic [tvsg_pkg::SAMPLE_W-1:0]   right_sample,
    output logic [7:0]                      port_a_out,
    output logic [7:0]                      port_b_out
);

    localparam int VW = tvsg_pkg::VOL_W;
    localparam int PW = VW + 8;
    localparam tvsg_pkg::vol_table_t VOL_ROM = tvsg_pkg::build_vol_rom(FULL_SCALE);

    logic [2:0][VW-1:0] part_next;
    logic [2:0][VW-1:0] part_reg;
    logic [7:0]         rd2_reg, pa2_reg, pb2_reg;
    logic               v2_reg;

    logic [2:0][PW-1:0] prod_l_reg, prod_r_reg;
    logic [VW+1:0]      mono_reg;
    logic [7:0]         rd3_reg, pa3_reg, pb3_reg;
    logic               v3_reg;

    logic [PW+1:0]      sum_l, sum_r;
    logic               out_valid_reg;
    logic [7:0]         rd_out_reg, pa_out_reg, pb_out_reg;
    logic [tvsg_pkg::SAMPLE_W-1:0] left_reg, right_reg;

    logic [5:0] env_pos;
    logic [4:0] env_q;
    logic       env_first;
    logic [4:0] env_level;
    logic [4:0] lvl;
    logic       gate;

    assign adv = !out_valid_reg || !out_stall;

    always_comb
    begin
        env_pos   = src.env_step | {5'd0, ay_mode};
        env_first = !env_pos[5];
        env_q     = env_pos[4:0];
        case (src.shape)
            4'd8:    env_level = ~env_q;
            4'd12:   env_level = env_q;
            4'd10:   env_level = env_first ? ~env_q : env_q;
            4'd14:   env_level = env_first ? env_q : ~env_q;
            4'd11:   env_level = env_first ? ~env_q : 5'd31;
            4'd13:   env_level = env_first ? env_q : 5'd31;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd15:
                     env_level = env_first ? env_q : 5'd0;
            default: env_level = env_first ? ~env_q : 5'd0;
        endcase
        lvl  = '0;
        gate = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            lvl = src.vol_ctrl[c][4] ? env_level
                                     : tvsg_pkg::fixed_level(src.vol_ctrl[c][3:0]);
            gate = (src.tone_sq[c] | src.mixer[c]) & (src.noise_sq | src.mixer[c+3]);
            part_next[c] = gate ? VOL_ROM[lvl] : '0;
        end
    end

    always_comb
    begin
        sum_l = (PW+2)'(prod_l_reg[0]) + (PW+2)'(prod_l_reg[1]) + (PW+2)'(prod_l_reg[2]);
        sum_r = (PW+2)'(prod_r_reg[0]) + (PW+2)'(prod_r_reg[1]) + (PW+2)'(prod_r_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg        <= src_valid;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // level stage
            part_reg <= part_next;
            rd2_reg  <= src.read_data;
            pa2_reg  <= src.mixer[6] ? src.port_a : 8'hff;
            pb2_reg  <= src.mixer[7] ? src.port_b : 8'hff;
            // product stage
            for (int c = 0; c < 3; c++)
            begin
                prod_l_reg[c] <= PW'(part_reg[c]) * PW'(weight[c]);
                prod_r_reg[c] <= PW'(part_reg[c]) * PW'(weight[c+3]);
            end
            mono_reg <= (VW+2)'(part_reg[0]) + (VW+2)'(part_reg[1]) + (VW+2)'(part_reg[2]);
            rd3_reg  <= rd2_reg;
            pa3_reg  <= pa2_reg;
            pb3_reg  <= pb2_reg;
            // output stage: in stereo mode drop the 1/256 weight scale
            left_reg   <= stereo_mode ? sum_l[8 +: tvsg_pkg::SAMPLE_W]
                                      : mono_reg[tvsg_pkg::SAMPLE_W-1:0];
            right_reg  <= stereo_mode ? sum_r[8 +: tvsg_pkg::SAMPLE_W]
                                      : mono_reg[tvsg_pkg::SAMPLE_W-1:0];
            rd_out_reg <= rd3_reg;
            pa_out_reg <= pa3_reg;
            pb_out_reg <= pb3_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_out_reg;
    assign left_sample  = left_reg;
    assign right_sample = right_reg;
    assign port_a_out   = pa_out_reg;
    assign port_b_out   = pb_out_reg;

endmodule

// ----- rtl/three_voice_sound_generator.sv -----
// Throughput: one request per cycle unless out_stall holds back a valid output;
// the four-stage pipeline (chip state, channel levels, weighted products,
// output register) advances together.
// Reset: chip registers, dividers and flags clear, noise shift register
// holds one, stereo mix on with all weights 255; the pipeline comes up empty.
// ----------------------------------------------------------------------------
// three_voice_sound_generator - three voice programmable sound generator
// Bus access and tick handling on sixteen chip registers, tone, noise and
// envelope dividers, followed by the mixing pipeline.
// ----------------------------------------------------------------------------
module three_voice_sound_generator #(
    parameter int FULL_SCALE = 32767
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  port_pins,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [14:0] left_sample,
    output logic [14:0] right_sample,
    output logic [7:0]  port_a_out,
    output logic [7:0]  port_b_out,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic              adv;
    logic              accept;
    tvsg_pkg::opcode_t op;

    logic [7:0]  regfile_reg  [16];
    logic [7:0]  regfile_next [16];
    logic [7:0]  sel_reg, sel_next;
    logic [2:0][12:0] tone_cnt_reg, tone_cnt_next;
    logic [2:0]  tone_sq_reg, tone_sq_next;
    logic [5:0]  noise_cnt_reg, noise_cnt_next;
    logic [16:0] lfsr_reg, lfsr_next;
    logic        noise_sq_reg, noise_sq_next;
    logic [16:0] env_cnt_reg, env_cnt_next;
    logic [5:0]  env_step_reg, env_step_next;
    logic [7:0]  rd_reg, rd_next;
    logic        v1_reg;

    logic            ay_mode_reg;
    logic            stereo_reg;
    logic [5:0][7:0] weight_reg;

    logic [3:0]         shape;
    tvsg_pkg::mix_src_t src;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !adv;
    assign op       = tvsg_pkg::opcode_t'(opcode);
    assign shape    = regfile_reg[tvsg_pkg::REG_ENV_SHAPE][3:0];

    always_comb
    begin
        regfile_next   = regfile_reg;
        sel_next       = sel_reg;
        tone_cnt_next  = tone_cnt_reg;
        tone_sq_next   = tone_sq_reg;
        noise_cnt_next = noise_cnt_reg;
        lfsr_next      = lfsr_reg;
        noise_sq_next  = noise_sq_reg;
        env_cnt_next   = env_cnt_reg;
        env_step_next  = env_step_reg;
        rd_next        = rd_reg;
        if (accept)
        begin
            rd_next = 8'hff;
            case (op)
                tvsg_pkg::OP_TICK:
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        if (tone_cnt_reg[c] != '0)
                        begin
                            tone_cnt_next[c] = tone_cnt_reg[c] - 13'd1;
                        end
                        else
                        begin
                            tone_sq_next[c]  = ~tone_sq_reg[c];
                            tone_cnt_next[c] = {regfile_reg[2*c+1][3:0], regfile_reg[2*c], 1'b0};
                        end
                    end
                    if (noise_cnt_reg != '0)
                    begin
                        noise_cnt_next = noise_cnt_reg - 6'd1;
                    end
                    else
                    begin
                        noise_cnt_next = {regfile_reg[tvsg_pkg::REG_NOISE_PER][4:0], 1'b0};
                        noise_sq_next  = noise_sq_reg ^ lfsr_reg[0];
                        lfsr_next      = {lfsr_reg[0] ^ lfsr_reg[3], lfsr_reg[16:1]};
                    end
                    if (env_cnt_reg != '0)
                    begin
                        env_cnt_next = env_cnt_reg - 17'd1;
                    end
                    else
                    begin
                        env_cnt_next = {regfile_reg[tvsg_pkg::REG_ENV_COARSE],
                                        regfile_reg[tvsg_pkg::REG_ENV_FINE], 1'b0};
                        // wrap for repeating shapes, hold at the end otherwise
                        if (env_step_reg == 6'd63)
                        begin
                            env_step_next = (shape[3] && !shape[0]) ? 6'd0 : 6'd63;
                        end
                        else
                        begin
                            env_step_next = env_step_reg + 6'd1;
                        end
                    end
                end
                tvsg_pkg::OP_LATCH:
                begin
                    sel_next = data_byte;
                end
                tvsg_pkg::OP_WRITE:
                begin
                    if (sel_reg[7:4] == 4'd0)
                    begin
                        regfile_next[sel_reg[3:0]] = data_byte;
                        if (sel_reg[3:0] == tvsg_pkg::REG_ENV_SHAPE)
                        begin
                            env_step_next = '0;
                        end
                    end
                end
                tvsg_pkg::OP_READ:
                begin
                    if (sel_reg == {4'd0, tvsg_pkg::REG_PORT_A})
                    begin
                        rd_next = port_pins & (regfile_reg[tvsg_pkg::REG_MIXER][6]
                                  ? regfile_reg[tvsg_pkg::REG_PORT_A] : 8'hff);
                    end
                    else if (sel_reg == {4'd0, tvsg_pkg::REG_PORT_B})
                    begin
                        rd_next = port_pins & (regfile_reg[tvsg_pkg::REG_MIXER][7]
                                  ? regfile_reg[tvsg_pkg::REG_PORT_B] : 8'hff);
                    end
                    else if (sel_reg[7:4] == 4'd0)
                    begin
                        rd_next = regfile_reg[sel_reg[3:0]] & tvsg_pkg::read_mask(sel_reg[3:0]);
                    end
                end
                default:
                begin
                    rd_next = 8'hff;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                regfile_reg[i] <= '0;
            end
            sel_reg       <= '0;
            tone_cnt_reg  <= '0;
            tone_sq_reg   <= '0;
            noise_cnt_reg <= '0;
            lfsr_reg      <= 17'd1;
            noise_sq_reg  <= 1'b0;
            env_cnt_reg   <= '0;
            env_step_reg  <= '0;
            v1_reg        <= 1'b0;
            ay_mode_reg   <= 1'b0;
            stereo_reg    <= 1'b1;
            weight_reg    <= {6{8'hff}};
        end
        else
        begin
            regfile_reg   <= regfile_next;
            sel_reg       <= sel_next;
            tone_cnt_reg  <= tone_cnt_next;
            tone_sq_reg   <= tone_sq_next;
            noise_cnt_reg <= noise_cnt_next;
            lfsr_reg      <= lfsr_next;
            noise_sq_reg  <= noise_sq_next;
            env_cnt_reg   <= env_cnt_next;
            env_step_reg  <= env_step_next;
            if (adv)
            begin
                v1_reg <= in_valid;
            end
            if (cfg_write)
            begin
                if (cfg_index == tvsg_pkg::CFG_AY_MODE)
                begin
                    ay_mode_reg <= cfg_data[0];
                end
                else if (cfg_index == tvsg_pkg::CFG_STEREO_MODE)
                begin
                    stereo_reg <= cfg_data[0];
                end
                else
                begin
                    weight_reg[cfg_index - tvsg_pkg::CFG_WEIGHT_BASE] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= rd_next;
    end

    always_comb
    begin
        src.tone_sq   = tone_sq_reg;
        src.noise_sq  = noise_sq_reg;
        src.mixer     = regfile_reg[tvsg_pkg::REG_MIXER];
        for (int c = 0; c < 3; c++)
        begin
            src.vol_ctrl[c] = regfile_reg[8+c][4:0];
        end
        src.shape     = shape;
        src.env_step  = env_step_reg;
        src.port_a    = regfile_reg[tvsg_pkg::REG_PORT_A];
        src.port_b    = regfile_reg[tvsg_pkg::REG_PORT_B];
        src.read_data = rd_reg;
    end

    tvsg_mixer #(
        .FULL_SCALE (FULL_SCALE)
    ) u_mixer (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (v1_reg),
        .src          (src),
        .ay_mode      (ay_mode_reg),
        .stereo_mode  (stereo_reg),
        .weight       (weight_reg),
        .out_stall    (out_stall),
        .adv          (adv),
        .out_valid    (out_valid),
        .read_data    (read_data),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .port_a_out   (port_a_out),
        .port_b_out   (port_b_out)
    );

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("noise shift register locked at zero");

    a_shape_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == tvsg_pkg::OP_WRITE && sel_reg == {4'd0, tvsg_pkg::REG_ENV_SHAPE}
        |=> env_step_reg == '0)
        else $error("envelope did not restart on shape write");

    a_latch: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == tvsg_pkg::OP_LATCH |=> sel_reg == $past(data_byte))
        else $error("latched register number lost");

    a_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept && op != tvsg_pkg::OP_READ |=> rd_reg == 8'hff)
        else $error("read data set by a request that is not a read");

endmodule
